/* rtl/bcc_pkg.sv */
package bcc_pkg;

  // Default counter widths
  localparam int DEBOUNCE_WIDTH_DEF = 8;
  localparam int TIME_WIDTH_DEF     = 16;

  // Register field widths
  localparam int DBT_W = 8;
  localparam int TMT_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd2;
  localparam logic [1:0] REG_ACTIVE_LVL = 2'd3;

  // Register reset values
  localparam logic [DBT_W-1:0] DEBOUNCE_RST   = 8'd20;
  localparam logic [TMT_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [TMT_W-1:0] DOUBLE_GAP_RST = 16'd300;
  localparam logic             ACTIVE_LVL_RST = 1'b0;

  // Request commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_FETCH   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  localparam logic [1:0] CLICK_LIMIT = 2'd2;

  typedef struct packed {
    logic [DBT_W-1:0] debounce_ticks;
    logic [TMT_W-1:0] long_press_ticks;
    logic [TMT_W-1:0] double_gap_ticks;
    logic             active_level;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [1:0] code;
  } rsp_t;

endpackage

/* rtl/bcc_if.sv */
interface bcc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       raw_level;

  modport source (output valid, output command, output raw_level, input ready);
  modport sink (input valid, input command, input raw_level, output ready);
endinterface

interface bcc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

/* rtl/bcc_cfg_regs.sv */
module bcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bcc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bcc_pkg::cfg_t                    cfg
);
  import bcc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RST;
      cfg.long_press_ticks <= LONG_PRESS_RST;
      cfg.double_gap_ticks <= DOUBLE_GAP_RST;
      cfg.active_level     <= ACTIVE_LVL_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE:   cfg.debounce_ticks   <= pwdata[DBT_W-1:0];
        REG_LONG_PRESS: cfg.long_press_ticks <= pwdata[TMT_W-1:0];
        REG_DOUBLE_GAP: cfg.double_gap_ticks <= pwdata[TMT_W-1:0];
        REG_ACTIVE_LVL: cfg.active_level     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE:   prdata = CFG_DATA_W'(cfg.debounce_ticks);
      REG_LONG_PRESS: prdata = CFG_DATA_W'(cfg.long_press_ticks);
      REG_DOUBLE_GAP: prdata = CFG_DATA_W'(cfg.double_gap_ticks);
      REG_ACTIVE_LVL: prdata = CFG_DATA_W'(cfg.active_level);
      default:        prdata = '0;
    endcase
  end

endmodule

/* rtl/bcc_core.sv */
module bcc_core #(
  parameter int DEBOUNCE_WIDTH = bcc_pkg::DEBOUNCE_WIDTH_DEF,
  parameter int TIME_WIDTH     = bcc_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bcc_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [1:0]    command,
  input  logic          raw_level,
  output bcc_pkg::rsp_t rsp
);
  import bcc_pkg::*;

  // compare widths cover both the counter and its threshold register
  localparam int DW = (DEBOUNCE_WIDTH > DBT_W) ? DEBOUNCE_WIDTH : DBT_W;
  localparam int TW = (TIME_WIDTH > TMT_W) ? TIME_WIDTH : TMT_W;
  localparam logic [DW-1:0] DB_MAX   = DW'({DEBOUNCE_WIDTH{1'b1}});
  localparam logic [TW-1:0] TIME_MAX = TW'({TIME_WIDTH{1'b1}});

  typedef enum logic [1:0] {PH_IDLE, PH_PRESSED, PH_WAIT} phase_t;

  logic                      stable_level, stable_level_next;
  logic                      previous_raw, previous_raw_next;
  logic [DEBOUNCE_WIDTH-1:0] debounce_count, debounce_count_next;
  logic [TIME_WIDTH-1:0]     hold_count, hold_count_next;
  logic [TIME_WIDTH-1:0]     gap_count, gap_count_next;
  logic [1:0]                clicks_seen, clicks_seen_next;
  logic                      long_done, long_done_next;
  phase_t                    phase, phase_next;
  logic [1:0]                pending_event, pending_event_next;

  logic          pressed;
  logic [DW-1:0] db_x, dt_x;
  logic [TW-1:0] hold_x, gap_x, lp_x, gt_x;

  assign db_x = DW'(debounce_count);
  assign dt_x = DW'(cfg.debounce_ticks);
  assign lp_x = TW'(cfg.long_press_ticks);
  assign gt_x = TW'(cfg.double_gap_ticks);

  always_comb begin
    stable_level_next   = stable_level;
    previous_raw_next   = previous_raw;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    gap_count_next      = gap_count;
    clicks_seen_next    = clicks_seen;
    long_done_next      = long_done;
    phase_next          = phase;
    pending_event_next  = pending_event;
    rsp.load            = 1'b0;
    rsp.code            = pending_event;
    pressed             = 1'b0;
    hold_x              = '0;
    gap_x               = '0;

    if (accept) begin
      case (command)
        CMD_TICK: begin
          // stability-count debouncer: the count restarts on every raw level change
          if (raw_level != previous_raw) begin
            previous_raw_next   = raw_level;
            debounce_count_next = '0;
          end else if (db_x < dt_x && db_x < DB_MAX) begin
            debounce_count_next = debounce_count + DEBOUNCE_WIDTH'(1);
            if (db_x + DW'(1) == dt_x) begin
              stable_level_next = raw_level;
            end
          end

          pressed = (stable_level_next == cfg.active_level);

          case (phase)
            PH_PRESSED: begin
              if (TW'(hold_count) < lp_x && TW'(hold_count) < TIME_MAX) begin
                hold_count_next = hold_count + TIME_WIDTH'(1);
              end
              hold_x = TW'(hold_count_next);
              if (!pressed) begin
                if (!long_done) begin
                  if (clicks_seen < CLICK_LIMIT) begin
                    clicks_seen_next = clicks_seen + 2'd1;
                  end
                  gap_count_next = '0;
                  phase_next     = PH_WAIT;
                end else begin
                  clicks_seen_next = '0;
                  phase_next       = PH_IDLE;
                end
              end else if (!long_done && hold_x >= lp_x) begin
                long_done_next = 1'b1;
                if (pending_event == EV_NONE) begin
                  pending_event_next = EV_LONG;
                end
              end
            end
            PH_WAIT: begin
              if (TW'(gap_count) < gt_x && TW'(gap_count) < TIME_MAX) begin
                gap_count_next = gap_count + TIME_WIDTH'(1);
              end
              gap_x = TW'(gap_count_next);
              if (pressed) begin
                phase_next      = PH_PRESSED;
                hold_count_next = '0;
              end else if (gap_x >= gt_x) begin
                if (pending_event == EV_NONE) begin
                  if (clicks_seen >= CLICK_LIMIT) begin
                    pending_event_next = EV_DOUBLE;
                  end else if (clicks_seen == 2'd1) begin
                    pending_event_next = EV_SINGLE;
                  end
                end
                clicks_seen_next = '0;
                phase_next       = PH_IDLE;
              end
            end
            default: begin
              phase_next = PH_IDLE;
              if (pressed) begin
                phase_next      = PH_PRESSED;
                hold_count_next = '0;
                long_done_next  = 1'b0;
              end
            end
          endcase
        end
        CMD_FETCH: begin
          rsp.load           = 1'b1;
          pending_event_next = EV_NONE;
        end
        CMD_RESTART: begin
          stable_level_next   = raw_level;
          previous_raw_next   = raw_level;
          debounce_count_next = '0;
          hold_count_next     = '0;
          gap_count_next      = '0;
          clicks_seen_next    = '0;
          long_done_next      = 1'b0;
          phase_next          = PH_IDLE;
          pending_event_next  = EV_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level   <= ~ACTIVE_LVL_RST;
      previous_raw   <= ~ACTIVE_LVL_RST;
      debounce_count <= '0;
      hold_count     <= '0;
      gap_count      <= '0;
      clicks_seen    <= '0;
      long_done      <= 1'b0;
      phase          <= PH_IDLE;
      pending_event  <= EV_NONE;
    end else begin
      stable_level   <= stable_level_next;
      previous_raw   <= previous_raw_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      gap_count      <= gap_count_next;
      clicks_seen    <= clicks_seen_next;
      long_done      <= long_done_next;
      phase          <= phase_next;
      pending_event  <= pending_event_next;
    end
  end

  // latched event is sticky until fetched or restarted
  a_event_sticky: assert property (@(posedge clk) disable iff (rst)
    (pending_event != EV_NONE &&
     !(accept && (command == CMD_FETCH || command == CMD_RESTART)))
    |=> pending_event == $past(pending_event))
    else $error("latched event overwritten");

  a_clicks_sat: assert property (@(posedge clk) disable iff (rst)
    clicks_seen <= CLICK_LIMIT)
    else $error("click count past limit");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_RESTART)
    |=> (phase == PH_IDLE && pending_event == EV_NONE && clicks_seen == 2'd0))
    else $error("restart did not clear state");

  a_fetch_code: assert property (@(posedge clk) disable iff (rst)
    rsp.load |-> rsp.code == pending_event)
    else $error("fetch returns wrong event");

endmodule

/* rtl/bcc_out_reg.sv */
module bcc_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  bcc_pkg::rsp_t rsp,
  output logic          in_ready,
  bcc_rsp_if.source     out
);
  import bcc_pkg::*;

  logic       res_valid;
  logic [1:0] res_code;

  // a slot frees up in the same cycle the held result is taken
  assign in_ready       = !res_valid || out.ready;
  assign out.valid      = res_valid;
  assign out.event_code = res_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rsp.load) begin
      res_valid <= 1'b1;
    end else if (out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.load) begin
      res_code <= rsp.code;
    end
  end

endmodule

/* rtl/button_click_classifier.sv */
// A fetch request shows its event on rsp in the cycle after acceptance.
// Throughput: one request per cycle; ticks and restarts never produce a result.
// The only stall is a held fetch result while rsp.ready is low.
// Reset (rst, synchronous, active high): registers to defaults, stable level
// inactive, machine idle, no event latched, result register empty.
module button_click_classifier #(
  parameter int DEBOUNCE_WIDTH = bcc_pkg::DEBOUNCE_WIDTH_DEF,
  parameter int TIME_WIDTH     = bcc_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bcc_req_if.sink                          req,
  bcc_rsp_if.source                        rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bcc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bcc_pkg::*;

  cfg_t cfg;       // live register values
  rsp_t core_rsp;  // fetch result heading for the output register
  logic accept;
  logic in_ready;

  // Register file: debounce, long press and gap thresholds, active level.
  bcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A request is taken whenever the result register can take a fetch result.
  assign req.ready = in_ready;
  assign accept    = req.valid & in_ready;

  // Debouncer and press classifier: all state updates at the accepting edge.
  bcc_core #(
    .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .command   (req.command),
    .raw_level (req.raw_level),
    .rsp       (core_rsp)
  );

  // Result register decouples downstream stalls from the request side.
  bcc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .rsp      (core_rsp),
    .in_ready (in_ready),
    .out      (rsp)
  );

endmodule
